// File: rtl/core/acmf_pkg.sv
`timescale 1ns / 1ps
// Package for the audio module command framer: payload structs, frame
// constants, request and register codes, and the volume clamp helper.
// No dependencies.
package acmf_pkg;

    // Frame sizes
    localparam int MAX_BYTES = 11;
    localparam int CNT_W     = 4;

    // Frame bytes
    localparam logic [7:0] FRAME_HEAD = 8'hAA;
    localparam logic [7:0] CMD_VOLUME = 8'h13;
    localparam logic [7:0] CMD_PLAY   = 8'h07;
    localparam logic [7:0] CMD_STOP   = 8'h04;
    localparam logic [7:0] LEN_VOLUME = 8'h01;
    localparam logic [7:0] LEN_PLAY   = 8'h02;
    localparam logic [7:0] LEN_STOP   = 8'h00;

    // Frame lengths in bytes
    localparam logic [CNT_W-1:0] VOL_BYTES  = 4'd5;
    localparam logic [CNT_W-1:0] PLAY_BYTES = 4'd6;
    localparam logic [CNT_W-1:0] STOP_BYTES = 4'd4;

    // Limits and offsets
    localparam logic [7:0]  VOL_MAX     = 8'd30;
    localparam logic [7:0]  VOL_NONE    = 8'd255;
    localparam logic [15:0] ENG_OFFSET  = 16'd40;
    localparam logic [15:0] ENG_LIMIT   = 16'd80;
    localparam logic [15:0] ALERT_LO    = 16'd1;
    localparam logic [15:0] ALERT_HI    = 16'd4;
    localparam logic [15:0] KEEP_LO     = 16'd34;
    localparam logic [15:0] KEEP_HI     = 16'd36;
    localparam logic [15:0] NAV_HI      = 16'd99;

    // Request codes
    localparam logic [1:0] FUNC_PLAY       = 2'd0;
    localparam logic [1:0] FUNC_PLAY_FORCE = 2'd1;
    localparam logic [1:0] FUNC_SET_VOLUME = 2'd2;
    localparam logic [1:0] FUNC_STOP       = 2'd3;

    // Register indexes
    localparam logic [1:0] CFG_ENGLISH   = 2'd0;
    localparam logic [1:0] CFG_NAV_EN    = 2'd1;
    localparam logic [1:0] CFG_ALERT_VOL = 2'd2;
    localparam logic [1:0] CFG_NAV_VOL   = 2'd3;

    // Register reset values
    localparam logic       RST_ENGLISH   = 1'b0;
    localparam logic       RST_NAV_EN    = 1'b1;
    localparam logic [7:0] RST_ALERT_VOL = 8'd30;
    localparam logic [7:0] RST_NAV_VOL   = 8'd15;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] track;
        logic [7:0]  volume;
    } t_in;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last;
    } t_out;

    typedef struct packed {
        logic       english_mode;
        logic       nav_sound_enabled;
        logic [7:0] alert_volume;
        logic [7:0] nav_volume;
    } t_cfg;

    // Bytes of one request, byte 0 goes out first
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [CNT_W-1:0]          count;
    } t_frame;

    function automatic logic [7:0] clamp_vol(input logic [7:0] vol);
        return (vol > VOL_MAX) ? VOL_MAX : vol;
    endfunction

endpackage

// File: rtl/core/acmf_decode.sv
`timescale 1ns / 1ps
// Request decoder: turns one registered request into the bytes of its frames.
// Depends on acmf_pkg.
module acmf_decode (
    input  acmf_pkg::t_in    i_req,
    input  acmf_pkg::t_cfg   i_cfg,
    input  logic [7:0]       i_sent_volume,
    output acmf_pkg::t_frame o_frame,
    output logic             o_vol_update,
    output logic [7:0]       o_vol_value
);

    logic        alert_track;
    logic        is_always;
    logic        dropped;
    logic [7:0]  want_vol;
    logic [7:0]  clamped;
    logic        vol_frame;
    logic [15:0] actual;
    logic [7:0]  vol_sum;
    logic [7:0]  play_sum;
    logic [4:0][7:0] vol_bytes;
    logic [5:0][7:0] play_bytes;
    logic [3:0][7:0] stop_bytes;

    // Track classification
    assign alert_track = (i_req.track >= acmf_pkg::ALERT_LO) &&
                         (i_req.track <= acmf_pkg::ALERT_HI);
    assign is_always = alert_track ||
                       ((i_req.track >= acmf_pkg::KEEP_LO) &&
                        (i_req.track <= acmf_pkg::KEEP_HI)) ||
                       ((i_req.track >= acmf_pkg::ENG_LIMIT) &&
                        (i_req.track <= acmf_pkg::NAV_HI));

    // Volume wanted by this request and whether a volume frame goes first
    always_comb begin
        want_vol = i_req.volume;
        if (i_req.func == acmf_pkg::FUNC_PLAY) begin
            want_vol = alert_track ? i_cfg.alert_volume : i_cfg.nav_volume;
        end
    end

    assign clamped = acmf_pkg::clamp_vol(want_vol);
    assign dropped = (i_req.func == acmf_pkg::FUNC_PLAY) && !is_always &&
                     !i_cfg.nav_sound_enabled;

    always_comb begin
        case (i_req.func)
            acmf_pkg::FUNC_SET_VOLUME: vol_frame = (clamped != i_sent_volume);
            acmf_pkg::FUNC_STOP:       vol_frame = 1'b0;
            default: vol_frame = !dropped && (want_vol != i_sent_volume) &&
                                 (clamped != i_sent_volume);
        endcase
    end

    // English offset on low tracks
    assign actual = (i_cfg.english_mode && (i_req.track < acmf_pkg::ENG_LIMIT)) ?
                    i_req.track + acmf_pkg::ENG_OFFSET : i_req.track;

    // Checksums: sum of all earlier frame bytes, modulo 256
    assign vol_sum  = acmf_pkg::FRAME_HEAD + acmf_pkg::CMD_VOLUME +
                      acmf_pkg::LEN_VOLUME + clamped;
    assign play_sum = acmf_pkg::FRAME_HEAD + acmf_pkg::CMD_PLAY +
                      acmf_pkg::LEN_PLAY + actual[15:8] + actual[7:0];

    // Frame byte lists, first byte in the lowest slot
    assign vol_bytes  = {vol_sum, clamped, acmf_pkg::LEN_VOLUME,
                         acmf_pkg::CMD_VOLUME, acmf_pkg::FRAME_HEAD};
    assign play_bytes = {play_sum, actual[7:0], actual[15:8], acmf_pkg::LEN_PLAY,
                         acmf_pkg::CMD_PLAY, acmf_pkg::FRAME_HEAD};
    assign stop_bytes = {acmf_pkg::FRAME_HEAD + acmf_pkg::CMD_STOP + acmf_pkg::LEN_STOP,
                         acmf_pkg::LEN_STOP, acmf_pkg::CMD_STOP, acmf_pkg::FRAME_HEAD};

    // Assemble the bytes of the whole request
    always_comb begin
        o_frame = '0;
        case (i_req.func)
            acmf_pkg::FUNC_SET_VOLUME: begin
                if (vol_frame) begin
                    o_frame.bytes[4:0] = vol_bytes;
                    o_frame.count      = acmf_pkg::VOL_BYTES;
                end
            end
            acmf_pkg::FUNC_STOP: begin
                o_frame.bytes[3:0] = stop_bytes;
                o_frame.count      = acmf_pkg::STOP_BYTES;
            end
            default: begin
                if (!dropped) begin
                    if (vol_frame) begin
                        o_frame.bytes[4:0]  = vol_bytes;
                        o_frame.bytes[10:5] = play_bytes;
                        o_frame.count       = acmf_pkg::VOL_BYTES + acmf_pkg::PLAY_BYTES;
                    end else begin
                        o_frame.bytes[5:0] = play_bytes;
                        o_frame.count      = acmf_pkg::PLAY_BYTES;
                    end
                end
            end
        endcase
    end

    assign o_vol_update = vol_frame;
    assign o_vol_value  = clamped;

endmodule

// File: rtl/core/acmf_serializer.sv
`timescale 1ns / 1ps
// Byte serializer: holds the bytes of one request in a shift register and
// sends them one beat at a time. Depends on acmf_pkg.
module acmf_serializer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  acmf_pkg::t_frame i_frame,
    output logic             o_free,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output acmf_pkg::t_out   o_out_data
);

    logic [acmf_pkg::MAX_BYTES-1:0][7:0] r_buf;
    logic [acmf_pkg::MAX_BYTES-1:0][7:0] n_buf;
    logic [acmf_pkg::CNT_W-1:0]          r_cnt;
    logic [acmf_pkg::CNT_W-1:0]          n_cnt;
    logic                                beat;

    assign o_out_valid = (r_cnt != '0);
    assign beat        = o_out_valid && !i_out_stall;
    // Free when empty or when the final byte leaves this cycle
    assign o_free      = (r_cnt == '0) || ((r_cnt == acmf_pkg::CNT_W'(1)) && beat);

    // Load a new request or shift out one byte per beat
    always_comb begin
        n_buf = r_buf;
        n_cnt = r_cnt;
        if (i_load) begin
            n_buf = i_frame.bytes;
            n_cnt = i_frame.count;
        end else if (beat) begin
            n_buf = r_buf >> 8;
            n_cnt = r_cnt - acmf_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_buf <= n_buf;
    end

    assign o_out_data.tx_byte = r_buf[0];
    assign o_out_data.last    = (r_cnt == acmf_pkg::CNT_W'(1));

endmodule

// File: rtl/core/audio_module_command_framer_unit.sv
`timescale 1ns / 1ps
// Top level of the audio module command framer: request register, config
// registers, volume cache, decoder and serializer. Depends on acmf_pkg,
// acmf_decode and acmf_serializer.
//
// Usage:
//   Request channel (i_in_valid / o_in_stall / i_in_data) takes one request
//   per beat: play, play at forced volume, set volume or stop.
//   Result channel (o_out_valid / i_out_stall / o_out_data) gives the frame
//   bytes one per beat, with last set on the final byte of a request.
//   Config channel (i_cfg_valid / o_cfg_ready) writes the four registers;
//   it is always ready and is meant to be used only while the block is idle.
// The request is registered, then loaded into the serializer, which drives its first byte.
// Throughput: one output byte per cycle while the receiver does not stall;
// a request has 0, 4, 5, 6 or 11 bytes and occupies the serializer until
// its last byte leaves, and the next request can be loaded as that byte leaves.
// A request that emits nothing leaves the request register without waiting for the serializer.
// While the receiver stalls, the current byte holds, the serializer stays
// full, and once the request register also holds a request with bytes, o_in_stall rises.
// Reset clears both valid paths, restores register defaults and marks the
// volume cache as "none sent".
module audio_module_command_framer_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  acmf_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output acmf_pkg::t_out  o_out_data,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [1:0]      i_cfg_index,
    input  logic [7:0]      i_cfg_data
);

    logic             r_in_valid;
    logic             n_in_valid;
    acmf_pkg::t_in    r_in;
    acmf_pkg::t_cfg   r_cfg;
    logic [7:0]       r_sent_volume;
    logic [7:0]       n_sent_volume;
    acmf_pkg::t_frame frame;
    logic             vol_update;
    logic [7:0]       vol_value;
    logic             ser_free;
    logic             consume;
    logic             load;
    logic             in_accept;

    // Request register handshake
    assign consume    = r_in_valid && ((frame.count == '0) || ser_free);
    assign load       = consume && (frame.count != '0);
    assign o_in_stall = r_in_valid && !consume;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_accept) begin
            n_in_valid = 1'b1;
        end else if (consume) begin
            n_in_valid = 1'b0;
        end
    end

    // Volume cache follows each decoded request in order
    assign n_sent_volume = (consume && vol_update) ? vol_value : r_sent_volume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_sent_volume <= acmf_pkg::VOL_NONE;
        end else begin
            r_in_valid    <= n_in_valid;
            r_sent_volume <= n_sent_volume;
        end
        if (in_accept) begin
            r_in <= i_in_data;
        end
    end

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.english_mode      <= acmf_pkg::RST_ENGLISH;
            r_cfg.nav_sound_enabled <= acmf_pkg::RST_NAV_EN;
            r_cfg.alert_volume      <= acmf_pkg::RST_ALERT_VOL;
            r_cfg.nav_volume        <= acmf_pkg::RST_NAV_VOL;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                acmf_pkg::CFG_ENGLISH:   r_cfg.english_mode      <= i_cfg_data[0];
                acmf_pkg::CFG_NAV_EN:    r_cfg.nav_sound_enabled <= i_cfg_data[0];
                acmf_pkg::CFG_ALERT_VOL: r_cfg.alert_volume      <= i_cfg_data;
                acmf_pkg::CFG_NAV_VOL:   r_cfg.nav_volume        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    acmf_decode u_decode (
        .i_req         (r_in),
        .i_cfg         (r_cfg),
        .i_sent_volume (r_sent_volume),
        .o_frame       (frame),
        .o_vol_update  (vol_update),
        .o_vol_value   (vol_value)
    );

    acmf_serializer u_serializer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_frame     (frame),
        .o_free      (ser_free),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // Cached volume is always a clamped value or the "none sent" mark
    a_sent_volume_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sent_volume <= acmf_pkg::VOL_MAX) || (r_sent_volume == acmf_pkg::VOL_NONE))
        else $error("volume cache out of range");

    // A byte that is not last is always followed by more bytes
    a_frame_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_out_data.last) |=> o_out_valid)
        else $error("request bytes cut short");

    // Input is only held off while the request register is occupied
    a_stall_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid)
        else $error("stall without a pending request");

    // The serializer is only loaded when it is free
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> ser_free)
        else $error("serializer overwritten");

endmodule

// File: sim/acmf_frame_checker.sv
`timescale 1ns / 1ps
// Frame checker for the audio module command framer: watches the request, result
// and register channels, predicts every frame byte and compares each result beat.
// Depends on acmf_pkg.
module acmf_frame_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_stall,
    input  acmf_pkg::t_in   i_in_data,
    input  logic            i_out_valid,
    input  logic            i_out_stall,
    input  acmf_pkg::t_out  i_out_data,
    input  logic            i_cfg_valid,
    input  logic            i_cfg_ready,
    input  logic [1:0]      i_cfg_index,
    input  logic [7:0]      i_cfg_data,
    output int              o_fail_count,
    output int              o_pending
);

    // Bytes still owed by the block, oldest first
    acmf_pkg::t_out expected_bytes_q[$];

    // Shadow registers and volume cache
    logic       english_q;
    logic       nav_en_q;
    logic [7:0] alert_vol_q;
    logic [7:0] nav_vol_q;
    logic [7:0] sent_vol_q;
    int         fail_cnt = 0;

    task automatic push_byte(input logic [7:0] b);
        acmf_pkg::t_out beat;
        beat.tx_byte = b;
        beat.last    = 1'b0;
        expected_bytes_q.push_back(beat);
    endtask

    // Head, command, length, data, then the running 8-bit sum
    task automatic push_frame(input logic [7:0] cmd, input logic [7:0] len,
                              input logic [15:0] data);
        logic [7:0] sum;
        sum = acmf_pkg::FRAME_HEAD + cmd + len;
        push_byte(acmf_pkg::FRAME_HEAD);
        push_byte(cmd);
        push_byte(len);
        if (len == acmf_pkg::LEN_PLAY) begin
            push_byte(data[15:8]);
            sum = sum + data[15:8];
        end
        if (len != acmf_pkg::LEN_STOP) begin
            push_byte(data[7:0]);
            sum = sum + data[7:0];
        end
        push_byte(sum);
    endtask

    // Volume frame only when the clamped level differs from the cache
    task automatic push_volume(input logic [7:0] vol);
        logic [7:0] level;
        level = (vol > acmf_pkg::VOL_MAX) ? acmf_pkg::VOL_MAX : vol;
        if (level != sent_vol_q) begin
            push_frame(acmf_pkg::CMD_VOLUME, acmf_pkg::LEN_VOLUME, {8'h00, level});
            sent_vol_q = level;
        end
    endtask

    task automatic push_play(input logic [15:0] track);
        logic [15:0] sent_track;
        sent_track = (english_q && track < acmf_pkg::ENG_LIMIT) ?
                     track + acmf_pkg::ENG_OFFSET : track;
        push_frame(acmf_pkg::CMD_PLAY, acmf_pkg::LEN_PLAY, sent_track);
    endtask

    // All bytes caused by one request; last marks the final one
    task automatic frame_request(input acmf_pkg::t_in req);
        int             start;
        logic           alert;
        logic           keep;
        logic [7:0]     target;
        acmf_pkg::t_out tail;
        start = expected_bytes_q.size();
        alert = (req.track >= acmf_pkg::ALERT_LO) && (req.track <= acmf_pkg::ALERT_HI);
        keep  = alert ||
                ((req.track >= acmf_pkg::KEEP_LO) && (req.track <= acmf_pkg::KEEP_HI)) ||
                ((req.track >= acmf_pkg::ENG_LIMIT) && (req.track <= acmf_pkg::NAV_HI));
        case (req.func)
            acmf_pkg::FUNC_PLAY: begin
                if (keep || nav_en_q) begin
                    target = alert ? alert_vol_q : nav_vol_q;
                    // compared unclamped: a level of 255 matches "none sent"
                    if (target != sent_vol_q) push_volume(target);
                    push_play(req.track);
                end
            end
            acmf_pkg::FUNC_PLAY_FORCE: begin
                if (req.volume != sent_vol_q) push_volume(req.volume);
                push_play(req.track);
            end
            acmf_pkg::FUNC_SET_VOLUME: begin
                push_volume(req.volume);
            end
            acmf_pkg::FUNC_STOP: begin
                push_frame(acmf_pkg::CMD_STOP, acmf_pkg::LEN_STOP, 16'h0000);
            end
            default: ;
        endcase
        if (expected_bytes_q.size() > start) begin
            tail = expected_bytes_q.pop_back();
            tail.last = 1'b1;
            expected_bytes_q.push_back(tail);
        end
    endtask

    // Channel monitor: register writes, requests, then result beats
    always @(posedge i_clk) begin : watch
        acmf_pkg::t_out want;
        if (!i_rst_n) begin
            english_q   = acmf_pkg::RST_ENGLISH;
            nav_en_q    = acmf_pkg::RST_NAV_EN;
            alert_vol_q = acmf_pkg::RST_ALERT_VOL;
            nav_vol_q   = acmf_pkg::RST_NAV_VOL;
            sent_vol_q  = acmf_pkg::VOL_NONE;
            expected_bytes_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    acmf_pkg::CFG_ENGLISH:   english_q   = i_cfg_data[0];
                    acmf_pkg::CFG_NAV_EN:    nav_en_q    = i_cfg_data[0];
                    acmf_pkg::CFG_ALERT_VOL: alert_vol_q = i_cfg_data;
                    acmf_pkg::CFG_NAV_VOL:   nav_vol_q   = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) frame_request(i_in_data);
            if (i_out_valid && !i_out_stall) begin
                if (expected_bytes_q.size() == 0) begin
                    $display("%0t: unexpected beat, actual byte %02h last %b",
                             $time, i_out_data.tx_byte, i_out_data.last);
                    fail_cnt++;
                end else begin
                    want = expected_bytes_q.pop_front();
                    if (i_out_data.tx_byte !== want.tx_byte) begin
                        $display("%0t: tx_byte mismatch, expected %02h actual %02h",
                                 $time, want.tx_byte, i_out_data.tx_byte);
                        fail_cnt++;
                    end
                    if (i_out_data.last !== want.last) begin
                        $display("%0t: last mismatch, expected %b actual %b",
                                 $time, want.last, i_out_data.last);
                        fail_cnt++;
                    end
                end
            end
        end
        o_pending    <= expected_bytes_q.size();
        o_fail_count <= fail_cnt;
    end

endmodule

// File: sim/audio_module_command_framer_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top for audio_module_command_framer_unit: drives requests, register
// writes and result stalls, and gives the verdict. Depends on acmf_pkg, the
// block and acmf_frame_checker.
module audio_module_command_framer_unit_tb;

    localparam int HOLD_CYCLES     = 80;
    localparam int QUIET_CYCLES    = 8;
    localparam int RANDOM_PHASES   = 5;
    localparam int ITEMS_PER_PHASE = 20;
    localparam int TIMEOUT_NS      = 2_000_000;

    logic           clk;
    logic           rst_n;
    logic           in_valid;
    logic           in_stall;
    acmf_pkg::t_in  in_data;
    logic           out_valid;
    logic           out_stall;
    acmf_pkg::t_out out_data;
    logic           cfg_valid;
    logic           cfg_ready;
    logic [1:0]     cfg_index;
    logic [7:0]     cfg_data;
    int             fail_count;
    int             pending;

    // Set by the stimulus, read by the stall process
    bit             hold_req = 1'b0;
    bit             idle_en  = 1'b1;

    audio_module_command_framer_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    acmf_frame_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Regression FAIL");
        $finish;
    end

    // Receiver: random stall before each beat, plus one long hold on request
    initial begin : receiver
        int waits;
        bit held;
        held = 1'b0;
        out_stall <= 1'b0;
        @(posedge clk);
        forever begin
            if (hold_req && !held) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                held = 1'b1;
            end
            waits = idle_en ? $urandom_range(0, 3) : 0;
            if (waits != 0) begin
                out_stall <= 1'b1;
                repeat (waits) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk);
            while (!(out_valid && !out_stall) && !(hold_req && !held));
        end
    end

    function automatic acmf_pkg::t_in make_req(input logic [1:0] func,
                                               input logic [15:0] track,
                                               input logic [7:0] volume);
        acmf_pkg::t_in req;
        req.func   = func;
        req.track  = track;
        req.volume = volume;
        return req;
    endfunction

    // Tracks lean toward the class boundaries, volumes toward the clamp
    function automatic acmf_pkg::t_in random_request();
        acmf_pkg::t_in req;
        int            pick;
        req.func = 2'($urandom_range(0, 3));
        pick = $urandom_range(0, 5);
        case (pick)
            0: req.track = 16'($urandom_range(0, 4));
            1: req.track = 16'($urandom_range(33, 37));
            2: req.track = 16'($urandom_range(78, 100));
            3: req.track = 16'($urandom_range(0, 79));
            4: req.track = 16'($urandom);
            default: req.track = 16'(16'hFFFF - $urandom_range(0, 3));
        endcase
        pick = $urandom_range(0, 3);
        case (pick)
            0: req.volume = 8'($urandom_range(0, 31));
            1: req.volume = 8'hFF;
            2: req.volume = 8'($urandom);
            default: req.volume = 8'($urandom_range(28, 31));
        endcase
        return req;
    endfunction

    function automatic logic [7:0] random_level();
        int pick;
        pick = $urandom_range(0, 4);
        case (pick)
            0: return 8'd0;
            1: return acmf_pkg::VOL_MAX;
            2: return acmf_pkg::VOL_MAX + 8'd1;
            3: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // One request beat; valid stays up across back-to-back beats
    task automatic send_request(input acmf_pkg::t_in req);
        int gap;
        gap = idle_en ? $urandom_range(0, 3) : 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic apply_config(input logic english, input logic nav_en,
                                input logic [7:0] alert_vol, input logic [7:0] nav_vol);
        cfg_valid <= 1'b1;
        write_reg(acmf_pkg::CFG_ENGLISH, {7'd0, english});
        write_reg(acmf_pkg::CFG_NAV_EN, {7'd0, nav_en});
        write_reg(acmf_pkg::CFG_ALERT_VOL, alert_vol);
        write_reg(acmf_pkg::CFG_NAV_VOL, nav_vol);
        cfg_valid <= 1'b0;
    endtask

    // Stop offering, wait out every owed byte, then let dropped requests clear
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    initial begin : stimulus
        int ph;
        int n;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= acmf_pkg::CFG_ENGLISH;
        cfg_data  <= 8'd0;
        rst_n     <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset registers; forced 255 matches the "none sent" cache
        send_request(make_req(acmf_pkg::FUNC_PLAY_FORCE, 16'd0, 8'hFF));
        send_request(make_req(acmf_pkg::FUNC_PLAY, 16'd0, 8'h00));
        send_request(make_req(acmf_pkg::FUNC_PLAY, 16'd1, 8'hFF));
        send_request(make_req(acmf_pkg::FUNC_PLAY, 16'd4, 8'h00));
        send_request(make_req(acmf_pkg::FUNC_SET_VOLUME, 16'hFFFF, 8'hFF));
        send_request(make_req(acmf_pkg::FUNC_SET_VOLUME, 16'd0, 8'd0));
        send_request(make_req(acmf_pkg::FUNC_STOP, 16'hFFFF, 8'hFF));
        send_request(make_req(acmf_pkg::FUNC_PLAY_FORCE, 16'hFFFF, 8'hFF));
        send_request(make_req(acmf_pkg::FUNC_PLAY_FORCE, 16'd5, 8'd30));
        send_request(make_req(acmf_pkg::FUNC_PLAY, 16'd79, 8'd0));
        send_request(make_req(acmf_pkg::FUNC_PLAY, 16'd80, 8'd0));
        send_request(make_req(acmf_pkg::FUNC_PLAY, 16'd100, 8'd0));
        send_request(make_req(acmf_pkg::FUNC_PLAY, 16'd34, 8'd0));
        drain();

        // English on, navigation muted, volumes at the extremes
        apply_config(1'b1, 1'b0, 8'hFF, 8'd0);
        send_request(make_req(acmf_pkg::FUNC_PLAY, 16'd0, 8'd0));
        send_request(make_req(acmf_pkg::FUNC_PLAY, 16'd1, 8'd0));
        send_request(make_req(acmf_pkg::FUNC_PLAY, 16'd79, 8'd0));
        send_request(make_req(acmf_pkg::FUNC_PLAY, 16'd80, 8'd0));
        send_request(make_req(acmf_pkg::FUNC_PLAY, 16'd99, 8'd0));
        send_request(make_req(acmf_pkg::FUNC_PLAY, 16'd35, 8'd0));
        send_request(make_req(acmf_pkg::FUNC_PLAY, 16'd37, 8'd0));
        send_request(make_req(acmf_pkg::FUNC_PLAY, 16'hFFFF, 8'd0));
        send_request(make_req(acmf_pkg::FUNC_PLAY_FORCE, 16'd79, 8'd31));
        send_request(make_req(acmf_pkg::FUNC_SET_VOLUME, 16'd0, 8'd29));
        send_request(make_req(acmf_pkg::FUNC_STOP, 16'd0, 8'd0));
        drain();

        // Random phases, each under its own register setting
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            apply_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         random_level(), random_level());
            idle_en = (ph != 1);
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (ph == 2 && n == 4) hold_req = 1'b1;
                send_request(random_request());
            end
            drain();
        end
        idle_en = 1'b1;

        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
